// ----- src/tpts_pkg.sv -----
package tpts_pkg;

	localparam int HEAP_DEPTH = 32;
	localparam int TIME_BITS  = 48;
	localparam int NUM_REC    = 2 * HEAP_DEPTH;
	localparam int REC_W      = $clog2(NUM_REC);
	localparam int HADDR_W    = $clog2(HEAP_DEPTH);
	localparam int HCNT_W     = $clog2(HEAP_DEPTH + 1);
	localparam int HIDX_W     = $clog2(2 * HEAP_DEPTH + 1);
	localparam int MAX_RES    = 32;
	localparam int RES_W      = $clog2(MAX_RES + 1);
	localparam int FIFO_AW    = $clog2(MAX_RES);
	localparam int PRIO_W     = 8;
	localparam int TICKET_W   = 32;
	localparam int AUX_W      = PRIO_W + TICKET_W;
	localparam int KEY_W      = (TIME_BITS > AUX_W) ? TIME_BITS : AUX_W;
	localparam int CHUNK_W    = 7;

	localparam logic [1:0] CMD_DEFER  = 2'd0;
	localparam logic [1:0] CMD_CANCEL = 2'd1;
	localparam logic [1:0] CMD_RUN    = 2'd2;

	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_TIMED_FULL = 2'd1;
	localparam logic [1:0] STAT_READY_FULL = 2'd2;

	typedef logic [1:0] cfg_idx_t;
	typedef logic [7:0] cfg_data_t;
	localparam cfg_idx_t REG_MIN_PRIO  = 2'd0;
	localparam cfg_idx_t REG_RUN_CHUNK = 2'd1;

	typedef struct packed {
		logic [1:0]           command;
		logic [TIME_BITS-1:0] time_value;
		logic [7:0]           priority_req;
		logic [7:0]           task_id;
		logic [15:0]          task_ref;
		logic signed [31:0]   task_arg;
	} item_t;

	typedef struct packed {
		logic                 fired;
		logic [7:0]           out_task_id;
		logic [15:0]          out_task_ref;
		logic signed [31:0]   out_task_arg;
		logic [1:0]           status;
		logic                 next_valid;
		logic [TIME_BITS-1:0] next_time;
		logic                 last;
	} result_t;

	typedef struct packed {
		logic [7:0]  id;
		logic [15:0] tref;
		logic [31:0] arg;
	} pay_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [AUX_W-1:0] aux;
		logic [REC_W-1:0] rec;
	} heap_entry_t;

	typedef struct packed {
		logic        push;
		logic        pop;
		heap_entry_t entry;
	} heap_req_t;

	typedef struct packed {
		logic              busy;
		logic [HCNT_W-1:0] count;
		heap_entry_t       top;
	} heap_stat_t;

	typedef struct packed {
		logic v;
		pay_t key;
	} tok_t;

	typedef struct packed {
		logic             alloc;
		logic             free;
		logic             cancel;
		logic [REC_W-1:0] idx;
		pay_t             key;
	} chain_op_t;

	// Ready ordering (by_prio): priority first, then a wrapping ticket (older first); otherwise plain key order.
	function automatic logic entry_lt(heap_entry_t a, heap_entry_t b, logic by_prio);
		logic [PRIO_W-1:0]   pa;
		logic [PRIO_W-1:0]   pb;
		logic [TICKET_W-1:0] d;
		pa = a.key[TICKET_W +: PRIO_W];
		pb = b.key[TICKET_W +: PRIO_W];
		d  = a.key[TICKET_W-1:0] - b.key[TICKET_W-1:0];
		if (by_prio) begin
			if (pa != pb) return pa < pb;
			return d[TICKET_W-1];
		end
		return a.key < b.key;
	endfunction

	function automatic logic entry_le(heap_entry_t a, heap_entry_t b, logic by_prio);
		logic [PRIO_W-1:0]   pa;
		logic [PRIO_W-1:0]   pb;
		logic [TICKET_W-1:0] d;
		pa = a.key[TICKET_W +: PRIO_W];
		pb = b.key[TICKET_W +: PRIO_W];
		d  = a.key[TICKET_W-1:0] - b.key[TICKET_W-1:0];
		if (by_prio) begin
			if (pa != pb) return pa < pb;
			return (d == '0) || d[TICKET_W-1];
		end
		return a.key <= b.key;
	endfunction

endpackage

// ----- src/tpts_ram.sv -----
module tpts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/tpts_cell.sv -----
module tpts_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  tpts_pkg::tok_t tok_in,
	output tpts_pkg::tok_t tok_out,
	input  logic          set,
	input  logic          clr,
	input  tpts_pkg::pay_t key_in,
	output logic          live,
	output logic          free
);
	import tpts_pkg::*;

	logic free_q;
	logic live_q;
	logic tok_v_q;
	pay_t key_q;
	pay_t tok_key_q;

	// A cancel key passes through one cell per cycle and kills a matching live record.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q  <= 1'b1;
			live_q  <= 1'b0;
			tok_v_q <= 1'b0;
		end else begin
			tok_v_q <= tok_in.v;
			if (set) begin
				free_q <= 1'b0;
				live_q <= 1'b1;
			end else if (clr) begin
				free_q <= 1'b1;
			end else if (tok_v_q && !free_q && live_q && tok_key_q == key_q) begin
				live_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_key_q <= tok_in.key;
		if (set) begin
			key_q <= key_in;
		end
	end

	assign tok_out.v   = tok_v_q;
	assign tok_out.key = tok_key_q;
	assign live        = live_q;
	assign free        = free_q;

endmodule

// ----- src/tpts_chain.sv -----
module tpts_chain (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tpts_pkg::chain_op_t           op,
	output logic [tpts_pkg::NUM_REC-1:0]  live,
	output logic [tpts_pkg::REC_W-1:0]    alloc_idx,
	output logic                          busy
);
	import tpts_pkg::*;

	tok_t              tok [NUM_REC+1];
	logic [NUM_REC-1:0] free;
	logic              busy_q;

	assign tok[0].v   = op.cancel;
	assign tok[0].key = op.key;

	for (genvar i = 0; i < NUM_REC; i++) begin : g_cell
		tpts_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1]),
			.set     (op.alloc && alloc_idx == REC_W'(i)),
			.clr     (op.free && op.idx == REC_W'(i)),
			.key_in  (op.key),
			.live    (live[i]),
			.free    (free[i])
		);
	end

	// Lowest free record.
	always_comb begin
		alloc_idx = '0;
		for (int i = NUM_REC - 1; i >= 0; i--) begin
			if (free[i]) alloc_idx = REC_W'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (op.cancel) begin
			busy_q <= 1'b1;
		end else if (tok[NUM_REC].v) begin
			busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;

endmodule

// ----- src/tpts_heap.sv -----
module tpts_heap (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  by_prio,
	input  tpts_pkg::heap_req_t   req,
	output tpts_pkg::heap_stat_t  stat
);
	import tpts_pkg::*;

	typedef enum logic [6:0] {
		H_IDLE    = 7'b0000001,
		H_UP_RD   = 7'b0000010,
		H_UP_CMP  = 7'b0000100,
		H_DN_LAST = 7'b0001000,
		H_DN_A    = 7'b0010000,
		H_DN_B    = 7'b0100000,
		H_DN_C    = 7'b1000000
	} hstate_t;

	hstate_t            state_q, st_d;
	logic [HCNT_W-1:0]  cnt_q, cnt_d;
	logic [HIDX_W-1:0]  idx_q, idx_d, chd_q, chd_d, par, pick_i;
	heap_entry_t        held_q, held_d, cand_q, cand_d, top_q, pick, wdata, rdata;
	logic               we, decide;
	logic [HADDR_W-1:0] waddr, raddr;

	tpts_ram #(.WIDTH($bits(heap_entry_t)), .DEPTH(HEAP_DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		st_d   = state_q;
		cnt_d  = cnt_q;
		held_d = held_q;
		idx_d  = idx_q;
		chd_d  = chd_q;
		cand_d = cand_q;
		we     = 1'b0;
		waddr  = idx_q[HADDR_W-1:0];
		wdata  = held_q;
		raddr  = '0;
		par    = (idx_q - 1'b1) >> 1;
		pick   = cand_q;
		pick_i = chd_q;
		decide = 1'b0;
		unique case (state_q)
			H_IDLE: begin
				if (req.push) begin
					held_d = req.entry;
					idx_d  = HIDX_W'(cnt_q);
					cnt_d  = cnt_q + 1'b1;
					st_d   = H_UP_RD;
				end else if (req.pop) begin
					cnt_d = cnt_q - 1'b1;
					raddr = HADDR_W'(cnt_q - 1'b1);
					if (cnt_q != HCNT_W'(1)) st_d = H_DN_LAST;
				end
			end
			H_UP_RD: begin
				if (idx_q == '0) begin
					we   = 1'b1;
					st_d = H_IDLE;
				end else begin
					raddr = par[HADDR_W-1:0];
					st_d  = H_UP_CMP;
				end
			end
			H_UP_CMP: begin
				we = 1'b1;
				if (entry_le(rdata, held_q, by_prio)) begin
					st_d = H_IDLE;
				end else begin
					wdata = rdata;
					idx_d = par;
					st_d  = H_UP_RD;
				end
			end
			H_DN_LAST: begin
				held_d = rdata;
				idx_d  = '0;
				chd_d  = HIDX_W'(1);
				st_d   = H_DN_A;
			end
			H_DN_A: begin
				if (chd_q >= HIDX_W'(cnt_q)) begin
					we   = 1'b1;
					st_d = H_IDLE;
				end else begin
					raddr = chd_q[HADDR_W-1:0];
					st_d  = H_DN_B;
				end
			end
			H_DN_B: begin
				if (chd_q + 1'b1 < HIDX_W'(cnt_q)) begin
					cand_d = rdata;
					raddr  = HADDR_W'(chd_q + 1'b1);
					st_d   = H_DN_C;
				end else begin
					decide = 1'b1;
					pick   = rdata;
				end
			end
			H_DN_C: begin
				decide = 1'b1;
				if (entry_lt(rdata, cand_q, by_prio)) begin
					pick   = rdata;
					pick_i = chd_q + 1'b1;
				end
			end
			default: st_d = H_IDLE;
		endcase
		if (decide) begin
			we = 1'b1;
			if (entry_le(held_q, pick, by_prio)) begin
				st_d = H_IDLE;
			end else begin
				wdata = pick;
				idx_d = pick_i;
				chd_d = {pick_i[HIDX_W-2:0], 1'b1};
				st_d  = H_DN_A;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= st_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		held_q <= held_d;
		idx_q  <= idx_d;
		chd_q  <= chd_d;
		cand_q <= cand_d;
		if (we && waddr == '0) begin
			top_q <= wdata;
		end
	end

	assign stat.busy  = (state_q != H_IDLE);
	assign stat.count = cnt_q;
	assign stat.top   = top_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= HCNT_W'(HEAP_DEPTH))
		else $error("heap count above depth");
	a_push_ok: assert property (@(posedge clk) disable iff (!arst_n)
		req.push |-> (state_q == H_IDLE && cnt_q < HCNT_W'(HEAP_DEPTH)))
		else $error("push while busy or full");
	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		req.pop |-> (state_q == H_IDLE && cnt_q != '0 && !req.push))
		else $error("pop while busy or empty");
`endif

endmodule

// ----- src/timed_priority_task_scheduler.sv -----
// Timed priority task scheduler.
// Commands enter on item when start is high and busy is low; that edge is the
// transfer. A defer stores a task with its due time, a cancel kills every
// pending task that matches id, reference and argument, and a run moves every
// task due strictly before the given time to the ready heap and fires from it.
// Each result is shown on result for one cycle while done is high; the
// receiver cannot stall, so the block never waits on the output side. The
// final result of a command carries last; status and next_time are the same
// on every result of one command.
// A defer sifts the new task up the timed heap level by level. A cancel waits
// while the key walks through the row of 64 record cells. A run moves due
// tasks and then pops ready tasks of priority at most min_priority, at most
// run_chunk of them (0 means no limit) and MAX_RES in all, each move and pop
// bounded by the heap memories, then emits fired tasks at one per cycle.
// Commands are processed one at a time.
// Configuration writes are taken whenever the block is idle (cfg_ready high).
// Reset leaves both heaps empty, all records free, min_priority 255 and
// run_chunk 0; no clearing pass is needed.
module timed_priority_task_scheduler (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  tpts_pkg::item_t     item,
	output logic                busy,
	output logic                done,
	output tpts_pkg::result_t   result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  tpts_pkg::cfg_idx_t  cfg_index,
	input  tpts_pkg::cfg_data_t cfg_data
);
	import tpts_pkg::*;

	typedef enum logic [14:0] {
		S_IDLE     = 15'b000000000000001,
		S_DEFER    = 15'b000000000000010,
		S_DF_WAIT  = 15'b000000000000100,
		S_CANCEL   = 15'b000000000001000,
		S_CA_WAIT  = 15'b000000000010000,
		S_MV_CHK   = 15'b000000000100000,
		S_MV_WAIT  = 15'b000000001000000,
		S_MV_DEC   = 15'b000000010000000,
		S_MV_PW    = 15'b000000100000000,
		S_PO_CHK   = 15'b000001000000000,
		S_PO_WAIT  = 15'b000010000000000,
		S_PO_FIRE  = 15'b000100000000000,
		S_PO_STORE = 15'b001000000000000,
		S_FIN      = 15'b010000000000000,
		S_EMIT     = 15'b100000000000000
	} state_t;

	state_t              state_q;
	item_t               cmd_q;
	logic [PRIO_W-1:0]   min_prio_q;
	logic [CHUNK_W-1:0]  run_chunk_q;
	logic [CHUNK_W-1:0]  budget_q;
	logic                all_q;
	logic [TICKET_W-1:0] ticket_q;
	logic [1:0]          status_q;
	logic [RES_W-1:0]    n_q;
	logic [REC_W-1:0]    rec_q;
	logic [AUX_W-1:0]    aux_q;
	logic [FIFO_AW-1:0]  k_q;
	logic                rd_v_s1;
	logic                zero_s1;
	logic                last_s1;
	logic                next_valid_q;
	logic [TIME_BITS-1:0] next_time_q;

	heap_req_t   t_req, r_req;
	heap_stat_t  t_stat, r_stat;
	chain_op_t   ch_op;
	logic [NUM_REC-1:0] live_vec;
	logic [REC_W-1:0]   alloc_idx;
	logic               ch_busy;
	pay_t               pay_in, pay_rd, fifo_rd;

	logic              tfull, rfull, due, pop_ok, rec_live, emit_end;
	logic [PRIO_W-1:0] r_top_prio;
	logic              nv;
	logic [TIME_BITS-1:0] nt;

	// The timed heap orders by due time, the ready heap by priority and ticket.
	tpts_heap u_timed (
		.clk     (clk),
		.arst_n  (arst_n),
		.by_prio (1'b0),
		.req     (t_req),
		.stat    (t_stat)
	);

	tpts_heap u_ready (
		.clk     (clk),
		.arst_n  (arst_n),
		.by_prio (1'b1),
		.req     (r_req),
		.stat    (r_stat)
	);

	// Record cells hold free and live flags plus the cancel key.
	tpts_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (ch_op),
		.live      (live_vec),
		.alloc_idx (alloc_idx),
		.busy      (ch_busy)
	);

	assign pay_in.id   = cmd_q.task_id;
	assign pay_in.tref = cmd_q.task_ref;
	assign pay_in.arg  = cmd_q.task_arg;

	// Task payload by record, read when a task fires.
	tpts_ram #(.WIDTH($bits(pay_t)), .DEPTH(NUM_REC)) u_pay_ram (
		.clk   (clk),
		.we    (state_q == S_DEFER && !tfull),
		.waddr (alloc_idx),
		.wdata (pay_in),
		.raddr (rec_q),
		.rdata (pay_rd)
	);

	// Fired tasks wait here until the command's final status is known.
	tpts_ram #(.WIDTH($bits(pay_t)), .DEPTH(MAX_RES)) u_fire_ram (
		.clk   (clk),
		.we    (state_q == S_PO_STORE),
		.waddr (n_q[FIFO_AW-1:0]),
		.wdata (pay_rd),
		.raddr (k_q),
		.rdata (fifo_rd)
	);

	assign tfull      = (t_stat.count >= HCNT_W'(HEAP_DEPTH));
	assign rfull      = (r_stat.count >= HCNT_W'(HEAP_DEPTH));
	assign due        = (t_stat.count != '0) &&
	                    (t_stat.top.key[TIME_BITS-1:0] < cmd_q.time_value);
	assign r_top_prio = r_stat.top.key[TICKET_W +: PRIO_W];
	assign pop_ok     = (all_q || budget_q != '0) && r_stat.count != '0 &&
	                    n_q < RES_W'(MAX_RES) && r_top_prio <= min_prio_q;
	assign rec_live   = live_vec[rec_q];
	assign emit_end   = (RES_W'(k_q) == n_q - 1'b1);

	// Next pending time after the command: zero if a ready task may run now.
	always_comb begin
		nv = 1'b0;
		nt = '0;
		if (r_stat.count != '0 && r_top_prio <= min_prio_q) begin
			nv = 1'b1;
		end else if (t_stat.count != '0) begin
			nv = 1'b1;
			nt = t_stat.top.key[TIME_BITS-1:0];
		end
	end

	// Requests to the heaps and the record chain.
	always_comb begin
		t_req             = '0;
		r_req             = '0;
		ch_op             = '0;
		ch_op.key         = pay_in;
		ch_op.idx         = rec_q;
		t_req.entry.key   = KEY_W'(cmd_q.time_value);
		t_req.entry.aux   = {cmd_q.priority_req, ticket_q};
		t_req.entry.rec   = alloc_idx;
		r_req.entry.key   = KEY_W'(aux_q);
		r_req.entry.aux   = '0;
		r_req.entry.rec   = rec_q;
		unique case (state_q)
			S_DEFER: begin
				if (!tfull) begin
					ch_op.alloc = 1'b1;
					t_req.push  = 1'b1;
				end
			end
			S_CANCEL: ch_op.cancel = 1'b1;
			S_MV_CHK: t_req.pop = due;
			S_MV_DEC: begin
				if (!rec_live || rfull) begin
					ch_op.free = 1'b1;
				end else begin
					r_req.push = 1'b1;
				end
			end
			S_PO_CHK:  r_req.pop  = pop_ok;
			S_PO_FIRE: ch_op.free = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			min_prio_q  <= '1;
			run_chunk_q <= '0;
			ticket_q    <= '0;
			rd_v_s1     <= 1'b0;
		end else begin
			rd_v_s1 <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_MIN_PRIO:  min_prio_q  <= cfg_data;
					REG_RUN_CHUNK: run_chunk_q <= cfg_data[CHUNK_W-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						unique case (item.command)
							CMD_DEFER:  state_q <= S_DEFER;
							CMD_CANCEL: state_q <= S_CANCEL;
							CMD_RUN:    state_q <= S_MV_CHK;
							default:    state_q <= S_FIN;
						endcase
					end
				end
				S_DEFER: begin
					ticket_q <= ticket_q + 1'b1;
					state_q  <= S_DF_WAIT;
				end
				S_DF_WAIT: if (!t_stat.busy) state_q <= S_FIN;
				S_CANCEL:  state_q <= S_CA_WAIT;
				S_CA_WAIT: if (!ch_busy) state_q <= S_FIN;
				S_MV_CHK:  state_q <= due ? S_MV_WAIT : S_PO_CHK;
				S_MV_WAIT: if (!t_stat.busy) state_q <= S_MV_DEC;
				S_MV_DEC: begin
					state_q <= (!rec_live || rfull) ? S_MV_CHK : S_MV_PW;
				end
				S_MV_PW:   if (!r_stat.busy) state_q <= S_MV_CHK;
				S_PO_CHK:  state_q <= pop_ok ? S_PO_WAIT : S_FIN;
				S_PO_WAIT: if (!r_stat.busy) state_q <= S_PO_FIRE;
				S_PO_FIRE: state_q <= rec_live ? S_PO_STORE : S_PO_CHK;
				S_PO_STORE: state_q <= S_PO_CHK;
				S_FIN: begin
					if (n_q == '0) begin
						rd_v_s1 <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					rd_v_s1 <= 1'b1;
					if (emit_end) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers of the command in flight.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd_q    <= item;
					status_q <= STAT_OK;
					n_q      <= '0;
					budget_q <= run_chunk_q;
					all_q    <= (run_chunk_q == '0);
				end
			end
			S_DEFER: if (tfull) status_q <= STAT_TIMED_FULL;
			S_MV_CHK: begin
				rec_q <= t_stat.top.rec;
				aux_q <= t_stat.top.aux;
			end
			S_MV_DEC: if (rec_live && rfull) status_q <= STAT_READY_FULL;
			S_PO_CHK: begin
				rec_q <= r_stat.top.rec;
				if (pop_ok && !all_q) budget_q <= budget_q - 1'b1;
			end
			S_PO_STORE: n_q <= n_q + 1'b1;
			S_FIN: begin
				next_valid_q <= nv;
				next_time_q  <= nt;
				k_q          <= '0;
				zero_s1      <= (n_q == '0);
				last_s1      <= (n_q == '0);
			end
			S_EMIT: begin
				k_q     <= k_q + 1'b1;
				zero_s1 <= 1'b0;
				last_s1 <= emit_end;
			end
			default: ;
		endcase
	end

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign done      = rd_v_s1;

	assign result.fired        = !zero_s1;
	assign result.out_task_id  = zero_s1 ? '0 : fifo_rd.id;
	assign result.out_task_ref = zero_s1 ? '0 : fifo_rd.tref;
	assign result.out_task_arg = zero_s1 ? '0 : fifo_rd.arg;
	assign result.status       = status_q;
	assign result.next_valid   = next_valid_q;
	assign result.next_time    = next_time_q;
	assign result.last         = last_s1;

`ifndef SYNTHESIS
	a_alloc_free_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ch_op.alloc && ch_op.free))
		else $error("record allocated and freed in one cycle");
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q != S_IDLE))
		else $error("accepted command did not start");
	a_fired_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_v_s1 && !zero_s1) |-> (n_q != '0))
		else $error("fired result without a stored task");
	a_fire_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (n_q <= RES_W'(MAX_RES)))
		else $error("too many fired tasks");
`endif

endmodule

// ----- tb/tb_timed_priority_task_scheduler.sv -----
module tb_timed_priority_task_scheduler;
	timeunit 1ns;
	timeprecision 1ps;

	import tpts_pkg::*;

	localparam int N_REC     = 2 * HEAP_DEPTH;
	localparam int TIMED     = 0;
	localparam int READY     = 1;
	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	item_t     item = '0;
	logic      busy;
	logic      done;
	result_t   result;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	cfg_idx_t  cfg_index = '0;
	cfg_data_t cfg_data = '0;

	timed_priority_task_scheduler u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item), .busy(busy),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Scheduler mirror: the record pool, both heaps and the two settings.
	logic [TIME_BITS-1:0] rec_due[N_REC];
	logic [7:0]           rec_id[N_REC];
	logic [15:0]          rec_ref[N_REC];
	logic [7:0]           rec_prio[N_REC];
	logic [31:0]          rec_arg[N_REC];
	logic [31:0]          rec_ticket[N_REC];
	bit                   rec_live[N_REC];
	bit                   rec_free[N_REC];
	int                   heap[2][HEAP_DEPTH];
	int                   heap_cnt[2];
	logic [31:0]          next_ticket;
	logic [7:0]           min_prio;
	logic [6:0]           chunk;

	result_t pending_results[$];
	bit      failed = 1'b0;
	int      idle_pct = 0;
	logic [TIME_BITS-1:0] now_ticks = 48'd1000;
	logic [55:0] used_keys[$];	// {task_id, task_ref, task_arg} of past defers

	function automatic int order_of(int sel, int a, int b);
		logic [31:0] d;
		if (sel == READY) begin
			if (rec_prio[a] != rec_prio[b]) return (rec_prio[a] < rec_prio[b]) ? -1 : 1;
			d = rec_ticket[a] - rec_ticket[b];
			if (d == 0) return 0;
			return d[31] ? -1 : 1;
		end
		if (rec_due[a] < rec_due[b]) return -1;
		if (rec_due[a] > rec_due[b]) return 1;
		return 0;
	endfunction

	function automatic void heap_push(int sel, int r);
		int c, p, t;
		c = heap_cnt[sel];
		heap[sel][c] = r;
		heap_cnt[sel]++;
		while (c > 0) begin
			p = (c - 1) / 2;
			if (order_of(sel, heap[sel][p], heap[sel][c]) <= 0) break;
			t = heap[sel][c];
			heap[sel][c] = heap[sel][p];
			heap[sel][p] = t;
			c = p;
		end
	endfunction

	function automatic int heap_pop(int sel);
		int top, p, c, held, n;
		top = heap[sel][0];
		heap_cnt[sel]--;
		n = heap_cnt[sel];
		heap[sel][0] = heap[sel][n];
		held = heap[sel][0];
		p = 0;
		c = 1;
		while (c < n) begin
			if (c + 1 < n && order_of(sel, heap[sel][c+1], heap[sel][c]) < 0) c = c + 1;
			if (order_of(sel, held, heap[sel][c]) <= 0) break;
			heap[sel][p] = heap[sel][c];
			p = c;
			c = 2 * p + 1;
		end
		heap[sel][p] = held;
		return top;
	endfunction

	function automatic void mirror_reset();
		for (int i = 0; i < N_REC; i++) rec_free[i] = 1'b1;
		heap_cnt[TIMED] = 0;
		heap_cnt[READY] = 0;
		next_ticket = '0;
		min_prio = 8'd255;
		chunk = '0;
	endfunction

	// Works out every result one command causes and queues them in order.
	function automatic void schedule_command(item_t it);
		result_t fires[$];
		result_t r;
		logic [1:0] stat;
		int budget, rec, slot;
		stat = STAT_OK;
		case (it.command)
			CMD_DEFER: begin
				if (heap_cnt[TIMED] >= HEAP_DEPTH) begin
					stat = STAT_TIMED_FULL;
				end else begin
					slot = 0;
					while (!rec_free[slot]) slot++;
					rec_free[slot] = 1'b0;
					rec_due[slot] = it.time_value;
					rec_id[slot] = it.task_id;
					rec_ref[slot] = it.task_ref;
					rec_prio[slot] = it.priority_req;
					rec_arg[slot] = it.task_arg;
					rec_ticket[slot] = next_ticket;
					rec_live[slot] = 1'b1;
					heap_push(TIMED, slot);
				end
				next_ticket++;
			end
			CMD_CANCEL: begin
				for (int s = 0; s < 2; s++)
					for (int i = 0; i < heap_cnt[s]; i++) begin
						rec = heap[s][i];
						if (rec_id[rec] == it.task_id && rec_ref[rec] == it.task_ref &&
								rec_arg[rec] == it.task_arg)
							rec_live[rec] = 1'b0;
					end
			end
			CMD_RUN: begin
				while (heap_cnt[TIMED] > 0 && rec_due[heap[TIMED][0]] < it.time_value) begin
					rec = heap_pop(TIMED);
					if (!rec_live[rec]) begin
						rec_free[rec] = 1'b1;
					end else if (heap_cnt[READY] >= HEAP_DEPTH) begin
						rec_free[rec] = 1'b1;
						stat = STAT_READY_FULL;
					end else begin
						heap_push(READY, rec);
					end
				end
				budget = chunk;
				while ((chunk == 0 || budget > 0) && heap_cnt[READY] > 0 &&
						fires.size() < MAX_RES && rec_prio[heap[READY][0]] <= min_prio) begin
					rec = heap_pop(READY);
					budget--;
					if (rec_live[rec]) begin
						r = '0;
						r.fired = 1'b1;
						r.out_task_id = rec_id[rec];
						r.out_task_ref = rec_ref[rec];
						r.out_task_arg = rec_arg[rec];
						fires.push_back(r);
					end
					rec_free[rec] = 1'b1;
				end
			end
			default: ;
		endcase
		if (fires.size() == 0) fires.push_back('0);
		foreach (fires[k]) begin
			r = fires[k];
			r.status = stat;
			r.next_valid = 1'b0;
			r.next_time = '0;
			if (heap_cnt[READY] > 0 && rec_prio[heap[READY][0]] <= min_prio) begin
				r.next_valid = 1'b1;
			end else if (heap_cnt[TIMED] > 0) begin
				r.next_valid = 1'b1;
				r.next_time = rec_due[heap[TIMED][0]];
			end
			r.last = (k == fires.size() - 1);
			pending_results.push_back(r);
		end
	endfunction

	// One command transfer. Start stays high across back-to-back transfers.
	task automatic send_cmd(logic [1:0] cmd, logic [TIME_BITS-1:0] t, logic [7:0] prio,
			logic [7:0] id, logic [15:0] tref, logic [31:0] arg);
		item_t it;
		it.command = cmd;
		it.time_value = t;
		it.priority_req = prio;
		it.task_id = id;
		it.task_ref = tref;
		it.task_arg = arg;
		@(negedge clk);
		if ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		item = it;
		start = 1'b1;
		do @(posedge clk); while (busy);
		schedule_command(it);
		if (cmd == CMD_DEFER) used_keys.push_back({id, tref, arg});
	endtask

	// Waits until every expected result has come and the block has gone idle.
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (pending_results.size() != 0 || busy) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, cfg_data_t value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_MIN_PRIO) min_prio = value;
		else if (idx == REG_RUN_CHUNK) chunk = value[6:0];
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_config(logic [7:0] mp, logic [6:0] ch);
		drain();
		write_reg(REG_MIN_PRIO, mp);
		write_reg(REG_RUN_CHUNK, {1'b0, ch});
	endtask

	// Runs everything that is due with no limits, so later tests start clean.
	task automatic flush_due();
		set_config(8'd255, 7'd0);
		repeat (3) send_cmd(CMD_RUN, now_ticks + 48'd100000, '0, '0, '0, '0);
		now_ticks += 48'd100000;
	endtask

	// Field extremes, every command, equal due times, cancel, a dead move, command 3.
	task automatic test_basic_commands();
		send_cmd(CMD_RUN, 48'd5, '0, '0, '0, '0);
		send_cmd(CMD_DEFER, 48'd10, 8'd255, 8'hFF, 16'hFFFF, 32'h7FFFFFFF);
		send_cmd(CMD_DEFER, 48'd10, 8'd0, 8'h00, 16'h0000, 32'h80000000);
		send_cmd(CMD_DEFER, 48'd10, 8'd0, 8'h5A, 16'hA5A5, 32'hFFFFFFFF);
		send_cmd(CMD_DEFER, 48'd0, 8'd7, 8'h12, 16'h3456, 32'h00000000);
		send_cmd(CMD_DEFER, 48'd20, 8'd3, 8'h01, 16'h0002, 32'h00000003);
		// Due time equal to now is not yet due.
		send_cmd(CMD_RUN, 48'd10, '0, '0, '0, '0);
		send_cmd(CMD_UNUSED, TIME_MAX, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFFFFFF);
		send_cmd(CMD_CANCEL, '0, '0, 8'h5A, 16'hA5A5, 32'hFFFFFFFF);
		send_cmd(CMD_CANCEL, '0, '0, 8'h99, 16'h9999, 32'h99999999);
		send_cmd(CMD_RUN, 48'd11, '0, '0, '0, '0);
		send_cmd(CMD_RUN, 48'd21, '0, '0, '0, '0);
		send_cmd(CMD_DEFER, TIME_MAX - 48'd1, 8'd1, 8'h33, 16'h4444, 32'h55555555);
		send_cmd(CMD_RUN, TIME_MAX, '0, '0, '0, '0);
		now_ticks = 48'd1000;
	endtask

	// Thirty-three defers overflow the timed heap; the last one is lost.
	task automatic test_timed_heap_full();
		flush_due();
		for (int i = 0; i <= HEAP_DEPTH; i++)
			send_cmd(CMD_DEFER, now_ticks + 48'($urandom_range(0, 3)),
				8'($urandom_range(1, 3)), 8'(i), 16'(i), 32'(i));
		flush_due();
	endtask

	// Priority floor holds 32 tasks in the ready heap; a further move overflows it,
	// a cancel leaves dead entries to pop, and a small chunk limits the pops.
	task automatic test_ready_heap_full();
		flush_due();
		set_config(8'd0, 7'd0);
		for (int i = 0; i < HEAP_DEPTH + 4; i++)
			send_cmd(CMD_DEFER, now_ticks + 48'(i), 8'd9, 8'hC0, i[15:0], 32'd7);
		send_cmd(CMD_RUN, now_ticks + 48'd200, '0, '0, '0, '0);
		send_cmd(CMD_DEFER, now_ticks + 48'd150, 8'd9, 8'hC1, 16'd0, 32'd7);
		send_cmd(CMD_RUN, now_ticks + 48'd200, '0, '0, '0, '0);
		send_cmd(CMD_CANCEL, '0, '0, 8'hC0, 16'd1, 32'd7);
		send_cmd(CMD_CANCEL, '0, '0, 8'hC0, 16'd2, 32'd7);
		set_config(8'd255, 7'd3);
		send_cmd(CMD_RUN, now_ticks + 48'd201, '0, '0, '0, '0);
		set_config(8'd255, 7'd64);
		send_cmd(CMD_RUN, now_ticks + 48'd202, '0, '0, '0, '0);
		now_ticks += 48'd300;
		flush_due();
	endtask

	// Register indexes outside the list must leave the settings alone.
	task automatic test_unused_registers();
		drain();
		write_reg(cfg_idx_t'(2), 8'hAA);
		write_reg(cfg_idx_t'(3), 8'h55);
		send_cmd(CMD_DEFER, now_ticks, 8'd200, 8'h42, 16'h4242, 32'h42);
		send_cmd(CMD_RUN, now_ticks + 48'd1, '0, '0, '0, '0);
	endtask

	// Mostly well-formed traffic around a moving clock, with a fresh setting every
	// forty commands; some cancels hit earlier keys, a few items are noise.
	task automatic test_random_traffic(int count, int pct);
		logic [55:0] k;
		int sel;
		idle_pct = pct;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				case ($urandom_range(4))
					0: set_config(8'd255, 7'd0);
					1: set_config(8'd0, 7'd64);
					2: set_config(8'($urandom_range(255)), 7'd1);
					default: set_config(8'($urandom_range(100, 255)),
						7'($urandom_range(0, 64)));
				endcase
			end
			sel = $urandom_range(99);
			if (sel < 50) begin
				send_cmd(CMD_DEFER, now_ticks + 48'($urandom_range(0, 60)),
					8'($urandom_range(0, 15) * ($urandom_range(3) == 0 ? 17 : 1)),
					8'($urandom), 16'($urandom), $urandom);
			end else if (sel < 62 && used_keys.size() > 0) begin
				k = used_keys[$urandom_range(used_keys.size() - 1)];
				send_cmd(CMD_CANCEL, 48'($urandom), 8'($urandom), k[55:48], k[47:32],
					k[31:0]);
			end else if (sel < 92) begin
				now_ticks += 48'($urandom_range(0, 40));
				send_cmd(CMD_RUN, now_ticks, 8'($urandom), 8'($urandom), 16'($urandom),
					$urandom);
			end else if (sel < 96) begin
				// Jump the clock so the upper time bits toggle too.
				now_ticks = 48'({$urandom, $urandom}) & 48'h7FFF_FFFF_FFFF;
				send_cmd(CMD_RUN, now_ticks, '0, '0, '0, '0);
			end else begin
				send_cmd(CMD_UNUSED, 48'({$urandom, $urandom}), 8'($urandom),
					8'($urandom), 16'($urandom), $urandom);
			end
			if (used_keys.size() > 64) void'(used_keys.pop_front());
		end
		drain();
	endtask

	// Each result transfer is compared with the oldest expected result.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result %p", result);
				failed = 1'b1;
			end else begin
				want = pending_results.pop_front();
				if (result.fired !== want.fired) begin
					$error("fired: expected %0d, got %0d", want.fired, result.fired);
					failed = 1'b1;
				end
				if (result.out_task_id !== want.out_task_id) begin
					$error("out_task_id: expected %0h, got %0h", want.out_task_id,
						result.out_task_id);
					failed = 1'b1;
				end
				if (result.out_task_ref !== want.out_task_ref) begin
					$error("out_task_ref: expected %0h, got %0h", want.out_task_ref,
						result.out_task_ref);
					failed = 1'b1;
				end
				if (result.out_task_arg !== want.out_task_arg) begin
					$error("out_task_arg: expected %0d, got %0d", want.out_task_arg,
						result.out_task_arg);
					failed = 1'b1;
				end
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					failed = 1'b1;
				end
				if (result.next_valid !== want.next_valid) begin
					$error("next_valid: expected %0d, got %0d", want.next_valid,
						result.next_valid);
					failed = 1'b1;
				end
				if (result.next_time !== want.next_time) begin
					$error("next_time: expected %0h, got %0h", want.next_time, result.next_time);
					failed = 1'b1;
				end
				if (result.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, result.last);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		mirror_reset();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_basic_commands();
		test_timed_heap_full();
		test_ready_heap_full();
		test_unused_registers();
		test_random_traffic(100, 29);
		test_random_traffic(100, 85);
		test_random_traffic(100, 0);
		drain();
		if (failed || pending_results.size() != 0) begin
			$display("Simulation FAILED");
		end else begin
			$display("Simulation PASSED");
		end
		$finish;
	end

	initial begin
		#50ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
